FILE: sv/cri_pkg.sv
// ============================================================================
// cri_pkg
// Shared types, constants and reset values of the color ramp interpolator.
// ============================================================================
package cri_pkg;

    // Ramp geometry
    localparam int STOPS         = 4;
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_W         = POS_FRAC_BITS + 1;   // stop position, Q1.16
    localparam int IN_W          = POS_W + 1;           // lookup position, signed Q2.16
    localparam int POS_ONE       = 1 << POS_FRAC_BITS;

    // Segments narrower than 1/SPAN_SCALE of 1.0 take the left stop's color
    localparam int SPAN_SCALE    = 10000;
    localparam int SPAN_MIN      = (POS_ONE + SPAN_SCALE - 1) / SPAN_SCALE;

    // Color channels
    localparam int CH_W          = 8;
    localparam int NCH           = 4;
    localparam int QUO_W         = CH_W;

    // Blend arithmetic widths
    localparam int NUM_W         = CH_W + POS_W;        // c_l*(span-d) + c_r*d
    localparam int DIV_W         = NUM_W + 1;           // 2*num + span
    localparam int DEN_W         = POS_W + 1;           // 2*span

    // Register file
    localparam int CNT_W         = 3;
    localparam int STOP_IDX_W    = $clog2(STOPS);
    localparam int REG_COUNT     = STOPS + 1;
    localparam int REG_IDX_W     = $clog2(REG_COUNT);
    localparam int ADDR_W        = REG_IDX_W + 3;
    localparam int DATA_W        = 64;
    localparam int STOP_W        = POS_W + NCH * CH_W;
    localparam int COUNT_RESET   = (4 > STOPS) ? STOPS : 4;

    // Register indexes
    localparam int REG_STOP_COUNT = 0;
    localparam int REG_STOP_BASE  = 1;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        chan_t alpha;
        chan_t red;
        chan_t green;
        chan_t blue;
    } argb_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        argb_t            color;
    } stop_t;

    localparam argb_t COLOR_BLACK = '{alpha: 8'hFF, red: 8'h00, green: 8'h00, blue: 8'h00};

    // Segment request: locate -> blend
    typedef struct packed {
        logic             valid;
        logic             direct;
        argb_t            color;
        argb_t            left;
        argb_t            right;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] offset;
    } seg_req_t;

    // Mix request: blend -> divide
    typedef struct packed {
        logic                        valid;
        logic                        direct;
        argb_t                       color;
        logic [NCH-1:0][NUM_W-1:0]   num;
        logic [POS_W-1:0]            span;
    } mix_req_t;

    // Default ramp: black at 0.0 and 0.486, white at 0.645 and 1.0
    function automatic stop_t stop_reset(input int idx);
        stop_t v;
        case (idx)
            0:       v = 49'd4278190080;
            1:       v = 49'd136798986567680;
            2:       v = 49'd181556857536511;
            3:       v = 49'd281479271677951;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/cri_regs.sv
// ============================================================================
// cri_regs
// APB register file: stop count and the ramp stops.
// ============================================================================
module cri_regs
    import cri_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    output logic [CNT_W-1:0]           stop_count,
    output stop_t [STOPS-1:0]          stops
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [CNT_W-1:0]     count_wdata;
    logic [CNT_W-1:0]     stop_count_reg;
    logic [CNT_W-1:0]     stop_count_next;
    stop_t [STOPS-1:0]    stops_reg;
    logic [DATA_W-1:0]    rd_data;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Saturate the stop count to the number of stop registers
    assign count_wdata     = pwdata[CNT_W-1:0];
    assign stop_count_next = (count_wdata > CNT_W'(STOPS)) ? CNT_W'(STOPS) : count_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= CNT_W'(COUNT_RESET);
            for (int i = 0; i < STOPS; i++)
            begin
                stops_reg[i] <= stop_reset(i);
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_IDX_W'(REG_STOP_COUNT))
            begin
                stop_count_reg <= stop_count_next;
            end
            for (int i = 0; i < STOPS; i++)
            begin
                if (reg_idx == REG_IDX_W'(REG_STOP_BASE + i))
                begin
                    stops_reg[i] <= stop_t'(pwdata[STOP_W-1:0]);
                end
            end
        end
    end

    // Read mux; unmapped addresses read as zero
    always_comb
    begin
        rd_data = '0;
        if (reg_idx == REG_IDX_W'(REG_STOP_COUNT))
        begin
            rd_data = DATA_W'(stop_count_reg);
        end
        for (int i = 0; i < STOPS; i++)
        begin
            if (reg_idx == REG_IDX_W'(REG_STOP_BASE + i))
            begin
                rd_data = DATA_W'(stops_reg[i]);
            end
        end
    end

    assign prdata     = rd_data;
    assign stop_count = stop_count_reg;
    assign stops      = stops_reg;

`ifndef ASSERT_OFF
    a_count_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        stop_count_reg <= CNT_W'(STOPS))
        else $error("stop count above number of stops");
`endif

endmodule

FILE: sv/cri_locate.sv
// ============================================================================
// cri_locate
// Clamp the lookup position, find its ramp segment and fetch the operands.
// ============================================================================
module cri_locate
    import cri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_accept,
    input  logic [IN_W-1:0]      ramp_pos,
    input  logic [CNT_W-1:0]     stop_count,
    input  stop_t [STOPS-1:0]    stops,
    output seg_req_t             seg_req
);

    typedef enum logic [1:0] {
        MODE_BLACK = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_SEG   = 2'd2
    } mode_t;

    // Stage 1: clamp
    logic                   s1_valid_reg;
    logic [POS_W-1:0]       s1_pos_reg;
    logic [POS_W-1:0]       s1_pos_next;

    // Stage 2: segment search
    logic                   s2_valid_reg;
    mode_t                  s2_mode_reg;
    mode_t                  s2_mode_next;
    logic [STOP_IDX_W-1:0]  s2_sel_reg;
    logic [STOP_IDX_W-1:0]  s2_sel_next;
    logic [POS_W-1:0]       s2_pos_reg;
    logic [STOPS-2:0]       match_vec;
    logic [STOP_IDX_W-1:0]  seg_sel;
    logic [POS_W-1:0]       last_pos;
    logic [STOP_IDX_W-1:0]  last_idx;

    // Stage 3: operand fetch
    logic                   s3_valid_reg;
    seg_req_t               s3_req_reg;
    seg_req_t               s3_req_next;
    logic [STOP_IDX_W-1:0]  right_idx;
    stop_t                  left_stop;
    stop_t                  right_stop;

    // Clamp to 0..1.0
    always_comb
    begin
        if (ramp_pos[IN_W-1])
        begin
            s1_pos_next = '0;
        end
        else if (ramp_pos[POS_W-1:0] > POS_W'(POS_ONE))
        begin
            s1_pos_next = POS_W'(POS_ONE);
        end
        else
        begin
            s1_pos_next = ramp_pos[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg <= s1_pos_next;
    end

    // Match every live segment, keep the first hit
    always_comb
    begin
        match_vec = '0;
        seg_sel   = '0;
        last_pos  = stops[0].pos;
        last_idx  = '0;
        for (int i = 0; i < STOPS - 1; i++)
        begin
            match_vec[i] = (CNT_W'(i + 2) <= stop_count) &&
                           (s1_pos_reg >= stops[i].pos) &&
                           (s1_pos_reg <= stops[i + 1].pos);
        end
        for (int i = STOPS - 2; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                seg_sel = STOP_IDX_W'(i);
            end
        end
        for (int i = 0; i < STOPS; i++)
        begin
            if (CNT_W'(i + 1) == stop_count)
            begin
                last_pos = stops[i].pos;
                last_idx = STOP_IDX_W'(i);
            end
        end
    end

    // Pick the color source
    always_comb
    begin
        s2_mode_next = MODE_BLACK;
        s2_sel_next  = '0;
        priority if (stop_count == '0)
        begin
            s2_mode_next = MODE_BLACK;
        end
        else if (stop_count == CNT_W'(1))
        begin
            s2_mode_next = MODE_STOP;
        end
        else if (|match_vec)
        begin
            s2_mode_next = MODE_SEG;
            s2_sel_next  = seg_sel;
        end
        else if (s1_pos_reg < stops[0].pos)
        begin
            s2_mode_next = MODE_STOP;
        end
        else if (s1_pos_reg > last_pos)
        begin
            s2_mode_next = MODE_STOP;
            s2_sel_next  = last_idx;
        end
        else
        begin
            s2_mode_next = MODE_BLACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg <= s2_mode_next;
        s2_sel_reg  <= s2_sel_next;
        s2_pos_reg  <= s1_pos_reg;
    end

    // Fetch segment ends, form span and offset
    assign right_idx  = (s2_sel_reg == STOP_IDX_W'(STOPS - 1)) ? s2_sel_reg
                                                               : STOP_IDX_W'(s2_sel_reg + 1'b1);
    assign left_stop  = stops[s2_sel_reg];
    assign right_stop = stops[right_idx];

    always_comb
    begin
        s3_req_next        = '0;
        s3_req_next.valid  = s2_valid_reg;
        s3_req_next.left   = left_stop.color;
        s3_req_next.right  = right_stop.color;
        s3_req_next.span   = right_stop.pos - left_stop.pos;
        s3_req_next.offset = s2_pos_reg - left_stop.pos;
        unique case (s2_mode_reg)
            MODE_SEG:
            begin
                s3_req_next.direct = (s3_req_next.span < POS_W'(SPAN_MIN));
                s3_req_next.color  = left_stop.color;
            end
            MODE_STOP:
            begin
                s3_req_next.direct = 1'b1;
                s3_req_next.color  = left_stop.color;
            end
            default:
            begin
                s3_req_next.direct = 1'b1;
                s3_req_next.color  = COLOR_BLACK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_req_reg <= s3_req_next;
    end

    always_comb
    begin
        seg_req       = s3_req_reg;
        seg_req.valid = s3_valid_reg;
    end

`ifndef ASSERT_OFF
    a_blend_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_req_reg.direct) |->
        (s3_req_reg.span >= POS_W'(SPAN_MIN)) && (s3_req_reg.offset <= s3_req_reg.span))
        else $error("blend request with span too small or offset outside segment");
`endif

endmodule

FILE: sv/cri_blend.sv
// ============================================================================
// cri_blend
// Weighted sum of the two segment end colors, one lane per channel.
// ============================================================================
module cri_blend
    import cri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seg_req_t  seg_req,
    output mix_req_t  mix_req
);

    logic [NCH-1:0][CH_W-1:0]  left_lanes;
    logic [NCH-1:0][CH_W-1:0]  right_lanes;
    logic [POS_W-1:0]          weight;
    logic                      mix_valid_reg;
    mix_req_t                  mix_reg;
    mix_req_t                  mix_next;

    assign left_lanes  = seg_req.left;
    assign right_lanes = seg_req.right;
    assign weight      = seg_req.span - seg_req.offset;

    // c_l * (span - d) + c_r * d per channel
    always_comb
    begin
        mix_next        = '0;
        mix_next.valid  = seg_req.valid;
        mix_next.direct = seg_req.direct;
        mix_next.color  = seg_req.color;
        mix_next.span   = seg_req.span;
        for (int c = 0; c < NCH; c++)
        begin
            mix_next.num[c] = NUM_W'(left_lanes[c])  * NUM_W'(weight) +
                              NUM_W'(right_lanes[c]) * NUM_W'(seg_req.offset);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            mix_valid_reg <= seg_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
    end

    always_comb
    begin
        mix_req       = mix_reg;
        mix_req.valid = mix_valid_reg;
    end

endmodule

FILE: sv/cri_divide.sv
// ============================================================================
// cri_divide
// Pipelined restoring divider, one quotient bit per stage, four lanes wide.
// Rounds half up by dividing (2*num + span) by 2*span.
// ============================================================================
module cri_divide
    import cri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mix_req_t  mix_req,
    output logic      done,
    output argb_t     color
);

    localparam int STEPS = QUO_W;

    logic [STEPS:0]        valid_reg;
    logic                  direct_reg [STEPS+1];
    argb_t                 color_reg  [STEPS+1];
    logic [DEN_W-1:0]      den_reg    [STEPS+1];
    logic [DIV_W-1:0]      rem_reg    [STEPS+1][NCH];
    logic [QUO_W-1:0]      quo_reg    [STEPS+1][NCH];

    logic                      done_reg;
    argb_t                     color_out_reg;
    argb_t                     color_out_next;
    logic [NCH-1:0][CH_W-1:0]  quo_lanes;
    logic [NCH-1:0]            lane_fit;

    // Form dividend and divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= mix_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        direct_reg[0] <= mix_req.direct;
        color_reg[0]  <= mix_req.color;
        den_reg[0]    <= {mix_req.span, 1'b0};
        for (int c = 0; c < NCH; c++)
        begin
            rem_reg[0][c] <= {mix_req.num[c], 1'b0} + DIV_W'(mix_req.span);
            quo_reg[0][c] <= '0;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= STEPS; j++)
    begin : g_step
        localparam int K = STEPS - j;

        logic [DIV_W-1:0] shifted;
        logic [NCH-1:0]   take;
        logic [DIV_W-1:0] rem_next [NCH];
        logic [QUO_W-1:0] quo_next [NCH];

        assign shifted = DIV_W'(den_reg[j-1]) << K;

        always_comb
        begin
            for (int c = 0; c < NCH; c++)
            begin
                take[c]     = (rem_reg[j-1][c] >= shifted);
                rem_next[c] = take[c] ? (rem_reg[j-1][c] - shifted) : rem_reg[j-1][c];
                quo_next[c] = {quo_reg[j-1][c][QUO_W-2:0], take[c]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            direct_reg[j] <= direct_reg[j-1];
            color_reg[j]  <= color_reg[j-1];
            den_reg[j]    <= den_reg[j-1];
            for (int c = 0; c < NCH; c++)
            begin
                rem_reg[j][c] <= rem_next[c];
                quo_reg[j][c] <= quo_next[c];
            end
        end
    end

    // Select stop color or interpolated quotient
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            quo_lanes[c] = quo_reg[STEPS][c];
            lane_fit[c]  = (rem_reg[STEPS][c] < DIV_W'(den_reg[STEPS]));
        end
        color_out_next = direct_reg[STEPS] ? color_reg[STEPS] : argb_t'(quo_lanes);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        color_out_reg <= color_out_next;
    end

    assign done  = done_reg;
    assign color = color_out_reg;

`ifndef ASSERT_OFF
    a_remainder_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STEPS] && !direct_reg[STEPS]) |-> (&lane_fit))
        else $error("quotient overflow: remainder not below divisor");
`endif

endmodule

FILE: sv/color_ramp_interpolator_unit.sv
// ============================================================================
// color_ramp_interpolator_unit
// Maps a lookup position to an ARGB color through a ramp of configured stops.
// ============================================================================
// Usage:
//   Requests: drive ramp_pos and raise start. A request is taken at every
//   rising edge with start high and busy low; busy stays low, so one lookup
//   can be issued in every clock cycle.
//   Results: done is high for exactly one cycle with red, green, blue and
//   alpha valid. Results come out in request order, one per cycle at full
//   rate. A request passes clamp, segment search, operand fetch, multiply
//   and dividend setup, then the 8-stage restoring divider that produces
//   one quotient bit per stage, and last the output register.
//   The receiver cannot stall: done is a strobe and results are not held.
//   Configuration: APB registers at 8-byte spacing, stop count at 0x00 and
//   stops at 0x08 upward. Write them only while no request is in flight.
//   Reset: rst_n clears the pipeline valid bits and loads the default
//   four-stop ramp; no request in flight survives reset.
// ============================================================================
module color_ramp_interpolator_unit
    import cri_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [IN_W-1:0]     ramp_pos,
    output logic                done,
    output logic [CH_W-1:0]     red,
    output logic [CH_W-1:0]     green,
    output logic [CH_W-1:0]     blue,
    output logic [CH_W-1:0]     alpha,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int LATENCY = 14;

    logic               req_accept;
    logic [CNT_W-1:0]   stop_count;
    stop_t [STOPS-1:0]  stops;
    seg_req_t           seg_req;
    mix_req_t           mix_req;
    argb_t              color;

    // Fully pipelined: never refuse a request
    assign busy       = 1'b0;
    assign req_accept = start && !busy;

    cri_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .stop_count (stop_count),
        .stops      (stops)
    );

    cri_locate u_locate (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .ramp_pos   (ramp_pos),
        .stop_count (stop_count),
        .stops      (stops),
        .seg_req    (seg_req)
    );

    cri_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_req (seg_req),
        .mix_req (mix_req)
    );

    cri_divide u_divide (
        .clk     (clk),
        .rst_n   (rst_n),
        .mix_req (mix_req),
        .done    (done),
        .color   (color)
    );

    assign red   = color.red;
    assign green = color.green;
    assign blue  = color.blue;
    assign alpha = color.alpha;

`ifndef ASSERT_OFF
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");
`endif

endmodule

FILE: dv/color_ramp_checker.sv
// ============================================================================
// color_ramp_checker
// Watches the lookup, result and register channels of the color ramp unit,
// predicts the color of every accepted lookup and compares each result with
// the oldest prediction still waiting.
// ============================================================================
module color_ramp_checker
    import cri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [IN_W-1:0]   ramp_pos,
    input  logic              done,
    input  chan_t             red,
    input  chan_t             green,
    input  chan_t             blue,
    input  chan_t             alpha,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending,
    output int                lookups,
    output int                reg_writes,
    output logic              timed_out
);
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted request, result or register write
    localparam int IDLE_LIMIT = 2000;

    // Power-up ramp: black at 0.0 and 0.486, white at 0.645 and 1.0
    localparam int DEFAULT_COUNT = 4;
    localparam logic [STOP_W-1:0] DEFAULT_RAMP [STOPS] = '{
        49'd4278190080,
        49'd136798986567680,
        49'd181556857536511,
        49'd281479271677951
    };

    stop_t ramp_stops [STOPS];
    int    stop_limit;
    argb_t expected_colors [$];
    argb_t oldest;
    int    idle_cycles;
    int    widx;
    bit    seen;

    // Round-half-up linear blend of one channel across a segment
    function automatic chan_t blend_channel(input chan_t lo, input chan_t hi,
                                            input longint offset, input longint span);
        longint mix;
        mix = longint'(lo) * (span - offset) + longint'(hi) * offset;
        return chan_t'((2 * mix + span) / (2 * span));
    endfunction

    function automatic argb_t predict_color(input logic [IN_W-1:0] raw);
        longint t;
        longint pl;
        longint pr;
        argb_t  res;
        int     i;
        t = longint'($signed(raw));
        if (t < 0)
            t = 0;
        if (t > POS_ONE)
            t = POS_ONE;
        res       = '0;
        res.alpha = 8'hFF;
        if (stop_limit == 0)
            return res;
        if (stop_limit == 1)
            return ramp_stops[0].color;
        // Take the first segment whose ends enclose the position
        for (i = 0; i < stop_limit - 1; i++)
        begin
            pl = longint'(ramp_stops[i].pos);
            pr = longint'(ramp_stops[i+1].pos);
            if (t >= pl && t <= pr)
            begin
                if ((pr - pl) * SPAN_SCALE < POS_ONE)
                    return ramp_stops[i].color;
                res.red   = blend_channel(ramp_stops[i].color.red,
                                          ramp_stops[i+1].color.red, t - pl, pr - pl);
                res.green = blend_channel(ramp_stops[i].color.green,
                                          ramp_stops[i+1].color.green, t - pl, pr - pl);
                res.blue  = blend_channel(ramp_stops[i].color.blue,
                                          ramp_stops[i+1].color.blue, t - pl, pr - pl);
                res.alpha = blend_channel(ramp_stops[i].color.alpha,
                                          ramp_stops[i+1].color.alpha, t - pl, pr - pl);
                return res;
            end
        end
        // Outside every segment: nearest end stop, else opaque black
        if (t < longint'(ramp_stops[0].pos))
            return ramp_stops[0].color;
        if (t > longint'(ramp_stops[stop_limit-1].pos))
            return ramp_stops[stop_limit-1].color;
        return res;
    endfunction

    task automatic check_channel(input string name, input chan_t want, input chan_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_limit = DEFAULT_COUNT;
            for (int i = 0; i < STOPS; i++)
                ramp_stops[i] = DEFAULT_RAMP[i];
            expected_colors.delete();
            fail_count  = 0;
            pending     = 0;
            lookups     = 0;
            reg_writes  = 0;
            idle_cycles = 0;
            timed_out   = 1'b0;
        end
        else
        begin
            seen = 1'b0;

            // Compare a returned color with the oldest prediction
            if (done === 1'b1)
            begin
                seen = 1'b1;
                if (expected_colors.size() == 0)
                begin
                    $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
                           red, green, blue, alpha);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_colors.pop_front();
                    check_channel("red", oldest.red, red);
                    check_channel("green", oldest.green, green);
                    check_channel("blue", oldest.blue, blue);
                    check_channel("alpha", oldest.alpha, alpha);
                end
            end

            // Predict each accepted request with the current ramp
            if (start === 1'b1 && busy === 1'b0)
            begin
                seen = 1'b1;
                expected_colors.push_back(predict_color(ramp_pos));
                lookups++;
            end

            // Track register writes; unknown indexes change nothing
            if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1)
            begin
                seen = 1'b1;
                reg_writes++;
                widx = int'(paddr[ADDR_W-1:3]);
                if (widx == REG_STOP_COUNT)
                    stop_limit = (pwdata[CNT_W-1:0] > STOPS) ? STOPS
                                                            : int'(pwdata[CNT_W-1:0]);
                else if (widx < REG_STOP_BASE + STOPS)
                    ramp_stops[widx - REG_STOP_BASE] = pwdata[STOP_W-1:0];
            end

            // Watchdog
            if (seen)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;

            pending = expected_colors.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// ============================================================================
// testbench
// Drives lookups and ramp register writes into the color ramp unit: directed
// positions on hand-built ramps, then random ramps with random lookups and
// random gaps. A checker beside the unit predicts and compares every color.
// ============================================================================
module testbench;
    import cri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [IN_W-1:0]   ramp_pos;
    logic              done;
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    chan_t             alpha;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   lookups;
    int   reg_writes;
    logic timed_out;

    // Ramp as last written, used to aim lookups near the stops
    stop_t ramp_plan [STOPS];
    int    plan_count;
    int    ramp_settings;

    color_ramp_interpolator_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ramp_pos (ramp_pos),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    color_ramp_checker ramp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ramp_pos   (ramp_pos),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .lookups    (lookups),
        .reg_writes (reg_writes),
        .timed_out  (timed_out)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly inside 0..1.0, some close to a stop, some over the full range
    function automatic int pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, POS_ONE);
        if (r < 8)
            return int'(ramp_plan[$urandom_range(0, STOPS-1)].pos)
                   + int'($urandom_range(0, 16)) - 8;
        return int'($urandom_range(0, (1 << IN_W) - 1)) - (1 << (IN_W - 1));
    endfunction

    task automatic issue_lookup(input int pos, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start    <= 1'b1;
        ramp_pos <= IN_W'(pos);
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic probe(input int pos);
        issue_lookup(pos, pick_gap());
    endtask

    task automatic run_random(input int count, input bit burst);
        repeat (count) issue_lookup(pick_pos(), burst ? 0 : pick_gap());
    endtask

    // Drop start and hold until every color has come back
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write count and all stops with noise in the unused bits, sometimes also an unmapped register
    task automatic write_ramp();
        logic [DATA_W-1:0] value;
        value = {$urandom, $urandom};
        value[CNT_W-1:0] = CNT_W'(plan_count);
        write_reg(REG_STOP_COUNT, value);
        for (int i = 0; i < STOPS; i++)
        begin
            value = {$urandom, $urandom};
            value[STOP_W-1:0] = ramp_plan[i];
            write_reg(REG_STOP_BASE + i, value);
        end
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(REG_COUNT, (1 << REG_IDX_W) - 1), {$urandom, $urandom});
        ramp_settings++;
    endtask

    task automatic set_stop(input int idx, input int pos, input logic [31:0] color);
        ramp_plan[idx].pos   = POS_W'(pos);
        ramp_plan[idx].color = color;
    endtask

    task automatic plan_random_ramp();
        int    mode;
        int    base;
        stop_t tmp;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, POS_ONE - 40);
        for (int i = 0; i < STOPS; i++)
        begin
            if (mode < 4)
                set_stop(i, $urandom_range(0, POS_ONE), $urandom);
            else if (mode < 6)
            begin
                base = base + $urandom_range(0, 10);
                set_stop(i, base, $urandom);
            end
            else if (mode < 8)
                set_stop(i, $urandom_range(0, 4) * (POS_ONE / 4), $urandom);
            else
                set_stop(i, $urandom_range(0, (1 << POS_W) - 1), $urandom);
        end
        // Sort into ascending order unless stops are meant to be scrambled
        if (mode < 8)
        begin
            for (int i = 0; i < STOPS - 1; i++)
                for (int j = 0; j < STOPS - 1 - i; j++)
                    if (ramp_plan[j].pos > ramp_plan[j+1].pos)
                    begin
                        tmp            = ramp_plan[j];
                        ramp_plan[j]   = ramp_plan[j+1];
                        ramp_plan[j+1] = tmp;
                    end
        end
        plan_count = ($urandom_range(0, 9) < 5) ? STOPS : $urandom_range(0, 7);
    endtask

    // Abort on a stalled run
    initial
    begin
        wait (timed_out === 1'b1);
        $display("color_ramp_interpolator_unit: mismatch");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        ramp_pos      = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        ramp_settings = 1;
        plan_count    = STOPS;
        set_stop(0, 0, 32'hFF000000);
        set_stop(1, 31850, 32'hFF000000);
        set_stop(2, 42271, 32'hFFFFFFFF);
        set_stop(3, POS_ONE, 32'hFFFFFFFF);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Power-up ramp: clamp limits and the stop positions themselves
        probe(-(1 << (IN_W - 1)));
        probe((1 << (IN_W - 1)) - 1);
        probe(-1);
        probe(0);
        probe(31850);
        probe(42271);
        probe(POS_ONE - 1);
        probe(POS_ONE);
        run_random(30, 1'b0);
        settle();

        // Narrow segment of span 6 next to one of span 7
        plan_count = 4;
        set_stop(0, 'h1000, 32'h80C04020);
        set_stop(1, 'h1006, 32'hFF102030);
        set_stop(2, 'h100D, 32'h00FFFFFF);
        set_stop(3, 'hF000, 32'hFFFFFFFF);
        write_ramp();
        probe(0);
        probe('h0FFF);
        probe('h1000);
        probe('h1003);
        probe('h1006);
        probe('h1009);
        probe('h100D);
        probe('h8000);
        probe('hF001);
        settle();

        // Single stop
        plan_count = 1;
        write_ramp();
        probe(0);
        probe(POS_ONE);
        settle();

        // No stops
        plan_count = 0;
        write_ramp();
        probe('h8000);
        settle();

        // Stops out of order
        plan_count = 3;
        set_stop(0, 'h8000, 32'h11223344);
        set_stop(1, 'h2000, 32'hA0B0C0D0);
        set_stop(2, 'hC000, 32'h5F6F7F8F);
        write_ramp();
        probe('h4000);
        probe('h9000);
        probe('hD000);
        settle();

        // Every stop at full scale, count beyond the stop array
        plan_count = 7;
        for (int i = 0; i < STOPS; i++)
            set_stop(i, (1 << POS_W) - 1, 32'hFFFFFFFF);
        write_ramp();
        probe(0);
        probe(POS_ONE);
        settle();

        // Every stop zero: all segments collapse
        plan_count = STOPS;
        for (int i = 0; i < STOPS; i++)
            set_stop(i, 0, 32'h00000000);
        write_ramp();
        run_random(40, 1'b0);
        settle();

        // Random ramps, some phases at full rate
        for (int phase = 0; phase < 12; phase++)
        begin
            plan_random_ramp();
            write_ramp();
            run_random(100, $urandom_range(0, 3) == 0);
            settle();
        end

        repeat (20) @(posedge clk);
        $display("checked %0d lookups over %0d ramp settings with %0d register writes",
                 lookups, ramp_settings, reg_writes);
        if (fail_count == 0)
            $display("color_ramp_interpolator_unit: match");
        else
            $display("color_ramp_interpolator_unit: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
sv/cri_pkg.sv
sv/cri_regs.sv
sv/cri_locate.sv
sv/cri_blend.sv
sv/cri_divide.sv
sv/color_ramp_interpolator_unit.sv
dv/color_ramp_checker.sv
dv/testbench.sv
